// File: rtl/sparse_polynomial_add_unit_assert.svh
// Assertion macros used by the sparse polynomial adder top level.
`ifndef SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define SPA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that, when true, must be followed by another in the next cycle.
`define SPA_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define SPA_ASSERT_ALWAYS(name, cond, msg)
`define SPA_ASSERT_NEXT(name, trig, cond, msg)
`endif
`endif

// File: rtl/spa_pkg.sv
// Types and constants shared by the sparse polynomial adder.
package spa_pkg;

    localparam int COEF_W      = 32;
    localparam int EXP_W       = 32;
    localparam int MAX_RESULTS = 32;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [EXP_W-1:0]  exp_t;

    // One stored term: exponent in the upper half, coefficient in the lower half.
    typedef struct packed {
        exp_t  exponent;
        coef_t coefficient;
    } term_word_t;

endpackage

// File: rtl/spa_term_if.sv
// Input channel carrying one polynomial term per item.
interface spa_term_if
    import spa_pkg::*;
();
    logic  valid;
    logic  ready;
    coef_t coefficient;
    exp_t  exponent;
    logic  term_present;
    logic  start_new;
    logic  last_term;

    modport source (
        output valid, coefficient, exponent, term_present, start_new, last_term,
        input  ready
    );
    modport sink (
        input  valid, coefficient, exponent, term_present, start_new, last_term,
        output ready
    );
endinterface

// File: rtl/spa_sum_if.sv
// Output channel carrying one term of the emitted sum per item.
interface spa_sum_if
    import spa_pkg::*;
();
    logic  valid;
    logic  ready;
    coef_t sum_coefficient;
    exp_t  sum_exponent;
    logic  last_of_sum;
    logic  overflowed;

    modport source (
        output valid, sum_coefficient, sum_exponent, last_of_sum, overflowed,
        input  ready
    );
    modport sink (
        input  valid, sum_coefficient, sum_exponent, last_of_sum, overflowed,
        output ready
    );
endinterface

// File: rtl/spa_term_mem.sv
// Term store: one write port and one read port with registered read data.
module spa_term_mem
    import spa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  term_word_t    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output term_word_t    rdata
);

    term_word_t mem [DEPTH];
    term_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sparse_polynomial_add_unit.sv
// Top level of the sparse polynomial adder: merge sequencer over two term stores.
//
//  Channel  Dir  Handshake     Contents
//  terms    in   valid/ready   coefficient, exponent, term_present, start_new, last_term
//  sums     out  valid/ready   sum_coefficient, sum_exponent, last_of_sum, overflowed
//
// An item is taken while idle. A present term reads and checks the merge tail when the
// merge is not empty, reads and checks each stored term it examines, and ends in a last
// step when it runs past the end of the stored sum; the store's registered read data sets
// the steps. A last item flushes each remaining stored term, finds the end, swaps stores,
// then reads and emits each term or emits the zero sum. Reset is asynchronous and clears
// all control state; the stores need no clearing. A stalled output only holds the emit.
`include "sparse_polynomial_add_unit_assert.svh"

module sparse_polynomial_add_unit
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    spa_term_if.sink    terms,
    spa_sum_if.source   sums
);

    localparam int CW      = $clog2(MAX_TERMS + 1);
    localparam int AW      = $clog2(MAX_TERMS);
    localparam int LIM_MAX = (MAX_TERMS < MAX_RESULTS) ? MAX_TERMS : MAX_RESULTS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_COPY_RD,
        S_COPY_CHK,
        S_FLUSH_RD,
        S_FLUSH_WR,
        S_SWAP,
        S_ZERO,
        S_EMIT_RD,
        S_EMIT_WR
    } state_t;

    state_t        state_reg, state_next;
    logic          active_reg, active_next;
    logic [CW-1:0] stored_count_reg, stored_count_next;
    logic [CW-1:0] merged_count_reg, merged_count_next;
    logic [CW-1:0] read_pointer_reg, read_pointer_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic [CW-1:0] emit_lim_reg, emit_lim_next;
    logic          emit_flag_reg, emit_flag_next;
    coef_t         coef_reg, coef_next;
    exp_t          exp_reg, exp_next;
    logic          last_reg, last_next;

    logic          out_valid_reg, out_valid_next;
    coef_t         out_coef_reg, out_coef_next;
    exp_t          out_exp_reg, out_exp_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    term_word_t    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    term_word_t    rdata0, rdata1;
    term_word_t    rd_word;
    logic          rd_dst;

    logic          app_en;
    term_word_t    app_word;
    logic [CW-1:0] tail_idx;
    logic [CW-1:0] wr_idx;
    coef_t         coef_sum;
    logic          out_free;
    logic          accept;
    state_t        after_term;

    assign accept   = terms.valid && terms.ready;
    assign out_free = !out_valid_reg || sums.ready;
    assign tail_idx = merged_count_reg - 1'b1;

    // The tail check reads the receiving store; every other read is of the active one.
    assign rd_dst  = (state_reg == S_TAIL_CHK);
    assign rd_word = (active_reg ^ rd_dst) ? rdata1 : rdata0;

    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        stored_count_next = stored_count_reg;
        merged_count_next = merged_count_reg;
        read_pointer_next = read_pointer_reg;
        overflow_next     = overflow_reg;
        emit_idx_next     = emit_idx_reg;
        emit_lim_next     = emit_lim_reg;
        emit_flag_next    = emit_flag_reg;
        coef_next         = coef_reg;
        exp_next          = exp_reg;
        last_next         = last_reg;
        out_valid_next    = out_valid_reg && !sums.ready;
        out_coef_next     = out_coef_reg;
        out_exp_next      = out_exp_reg;
        out_last_next     = out_last_reg;
        out_ovf_next      = out_ovf_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        app_en            = 1'b0;
        app_word          = '0;
        wr_idx            = '0;
        coef_sum          = '0;
        after_term        = last_reg ? S_FLUSH_RD : S_IDLE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    coef_next = terms.coefficient;
                    exp_next  = terms.exponent;
                    last_next = terms.last_term;
                    if (terms.start_new)
                    begin
                        stored_count_next = '0;
                        merged_count_next = '0;
                        read_pointer_next = '0;
                        overflow_next     = 1'b0;
                    end
                    if (terms.term_present)
                    begin
                        if (!terms.start_new && merged_count_reg != '0)
                        begin
                            state_next = S_TAIL_RD;
                        end
                        else
                        begin
                            state_next = S_COPY_RD;
                        end
                    end
                    else
                    begin
                        state_next = terms.last_term ? S_FLUSH_RD : S_IDLE;
                    end
                end
            end

            S_TAIL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = tail_idx[AW-1:0];
                state_next = S_TAIL_CHK;
            end

            S_TAIL_CHK:
            begin
                coef_sum = rd_word.coefficient + coef_reg;
                if ($signed(exp_reg) < $signed(rd_word.exponent))
                begin
                    // A falling exponent is ignored.
                    state_next = after_term;
                end
                else if (exp_reg == rd_word.exponent)
                begin
                    if (coef_sum == '0)
                    begin
                        merged_count_next = tail_idx;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        wr_idx    = tail_idx;
                        mem_waddr = tail_idx[AW-1:0];
                        mem_wdata = '{exponent: exp_reg, coefficient: coef_sum};
                    end
                    state_next = after_term;
                end
                else
                begin
                    state_next = S_COPY_RD;
                end
            end

            S_COPY_RD:
            begin
                if (read_pointer_reg < stored_count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = read_pointer_reg[AW-1:0];
                    state_next = S_COPY_CHK;
                end
                else
                begin
                    app_en     = (coef_reg != '0);
                    app_word   = '{exponent: exp_reg, coefficient: coef_reg};
                    state_next = after_term;
                end
            end

            S_COPY_CHK:
            begin
                coef_sum = coef_reg + rd_word.coefficient;
                if ($signed(rd_word.exponent) < $signed(exp_reg))
                begin
                    app_en            = 1'b1;
                    app_word          = rd_word;
                    read_pointer_next = read_pointer_reg + 1'b1;
                    state_next        = S_COPY_RD;
                end
                else if (rd_word.exponent == exp_reg)
                begin
                    read_pointer_next = read_pointer_reg + 1'b1;
                    app_en            = (coef_sum != '0);
                    app_word          = '{exponent: exp_reg, coefficient: coef_sum};
                    state_next        = after_term;
                end
                else
                begin
                    app_en     = (coef_reg != '0);
                    app_word   = '{exponent: exp_reg, coefficient: coef_reg};
                    state_next = after_term;
                end
            end

            S_FLUSH_RD:
            begin
                if (read_pointer_reg < stored_count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = read_pointer_reg[AW-1:0];
                    state_next = S_FLUSH_WR;
                end
                else
                begin
                    state_next = S_SWAP;
                end
            end

            S_FLUSH_WR:
            begin
                app_en            = 1'b1;
                app_word          = rd_word;
                read_pointer_next = read_pointer_reg + 1'b1;
                state_next        = S_FLUSH_RD;
            end

            S_SWAP:
            begin
                active_next       = !active_reg;
                stored_count_next = merged_count_reg;
                merged_count_next = '0;
                read_pointer_next = '0;
                emit_idx_next     = '0;
                if (int'(merged_count_reg) > MAX_RESULTS)
                begin
                    emit_lim_next  = CW'(LIM_MAX);
                    emit_flag_next = 1'b1;
                end
                else
                begin
                    emit_lim_next  = merged_count_reg;
                    emit_flag_next = overflow_reg;
                end
                state_next = (merged_count_reg == '0) ? S_ZERO : S_EMIT_RD;
            end

            S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = '0;
                    out_exp_next   = '0;
                    out_last_next  = 1'b1;
                    out_ovf_next   = overflow_reg;
                    state_next     = S_IDLE;
                end
            end

            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = emit_idx_reg[AW-1:0];
                state_next = S_EMIT_WR;
            end

            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = rd_word.coefficient;
                    out_exp_next   = rd_word.exponent;
                    out_last_next  = (emit_idx_reg + 1'b1 == emit_lim_reg);
                    out_ovf_next   = emit_flag_reg;
                    emit_idx_next  = emit_idx_reg + 1'b1;
                    state_next     = (emit_idx_reg + 1'b1 == emit_lim_reg) ? S_IDLE : S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append to the receiving store, or drop the term and flag it when full.
        if (app_en)
        begin
            if (merged_count_reg < CW'(MAX_TERMS))
            begin
                mem_we            = 1'b1;
                wr_idx            = merged_count_reg;
                mem_waddr         = merged_count_reg[AW-1:0];
                mem_wdata         = app_word;
                merged_count_next = merged_count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= 1'b0;
            stored_count_reg <= '0;
            merged_count_reg <= '0;
            read_pointer_reg <= '0;
            overflow_reg     <= 1'b0;
            emit_idx_reg     <= '0;
            emit_lim_reg     <= '0;
            emit_flag_reg    <= 1'b0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            stored_count_reg <= stored_count_next;
            merged_count_reg <= merged_count_next;
            read_pointer_reg <= read_pointer_next;
            overflow_reg     <= overflow_next;
            emit_idx_reg     <= emit_idx_next;
            emit_lim_reg     <= emit_lim_next;
            emit_flag_reg    <= emit_flag_next;
            last_reg         <= last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg     <= coef_next;
        exp_reg      <= exp_next;
        out_coef_reg <= out_coef_next;
        out_exp_reg  <= out_exp_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    spa_term_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_store0 (
        .clk   (clk),
        .we    (mem_we && active_reg),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata0)
    );

    spa_term_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_store1 (
        .clk   (clk),
        .we    (mem_we && !active_reg),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata1)
    );

    assign terms.ready          = (state_reg == S_IDLE);
    assign sums.valid           = out_valid_reg;
    assign sums.sum_coefficient = out_coef_reg;
    assign sums.sum_exponent    = out_exp_reg;
    assign sums.last_of_sum     = out_last_reg;
    assign sums.overflowed      = out_ovf_reg;

    `SPA_ASSERT_ALWAYS(a_counts_bounded,
        merged_count_reg <= CW'(MAX_TERMS) && stored_count_reg <= CW'(MAX_TERMS),
        "term count exceeds store depth")
    `SPA_ASSERT_ALWAYS(a_pointer_in_sum, read_pointer_reg <= stored_count_reg,
        "read pointer ran past the stored sum")
    `SPA_ASSERT_ALWAYS(a_write_in_range, !mem_we || wr_idx < CW'(MAX_TERMS),
        "store write beyond its depth")
    `SPA_ASSERT_NEXT(a_swap_resets_merge, state_reg == S_SWAP,
        merged_count_reg == '0 && read_pointer_reg == '0 &&
        stored_count_reg == $past(merged_count_reg),
        "store swap left merge state behind")
    `SPA_ASSERT_ALWAYS(a_emit_limit, emit_lim_reg <= CW'(LIM_MAX),
        "emit count above result limit")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the sparse polynomial adder with a scoreboard-based term predictor.
`timescale 1ns / 100ps

module tb_top
    import spa_pkg::*;
();

    localparam int STORE_DEPTH   = 32;
    localparam int RANDOM_TERMS  = 420;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        coef_t coefficient;
        exp_t  exponent;
        logic  last_of_sum;
        logic  overflowed;
    } sum_term_t;

    // Tracks the running sum in two term stores, the way the block does, and
    // holds the sum terms still to come out.
    class poly_sum_scoreboard;
        term_word_t  store[2][STORE_DEPTH];
        bit          active;
        int unsigned stored_n;
        int unsigned merged_n;
        int unsigned rd_ptr;
        bit          lost;
        sum_term_t   expected_terms[$];
        int unsigned errors;

        function new();
            active   = 1'b0;
            stored_n = 0;
            merged_n = 0;
            rd_ptr   = 0;
            lost     = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_terms.size();
        endfunction

        function void append_merged(term_word_t w);
            if (merged_n < STORE_DEPTH)
            begin
                store[active ^ 1'b1][merged_n] = w;
                merged_n++;
            end
            else
            begin
                lost = 1'b1;
            end
        endfunction

        function void copy_lower(exp_t e, bit all);
            while (rd_ptr < stored_n && rd_ptr < STORE_DEPTH &&
                   (all || $signed(store[active][rd_ptr].exponent) < $signed(e)))
            begin
                append_merged(store[active][rd_ptr]);
                rd_ptr++;
            end
        endfunction

        function void merge_term(coef_t c, exp_t e);
            term_word_t tail;
            coef_t      total;
            term_word_t fresh_word;
            // A term that meets the tail of the merge is either dropped or folded in.
            if (merged_n > 0)
            begin
                tail = store[active ^ 1'b1][merged_n - 1];
                if ($signed(e) < $signed(tail.exponent))
                    return;
                if (e == tail.exponent)
                begin
                    total = tail.coefficient + c;
                    if (total == '0)
                        merged_n--;
                    else
                        store[active ^ 1'b1][merged_n - 1].coefficient = total;
                    return;
                end
            end
            copy_lower(e, 1'b0);
            if (rd_ptr < stored_n && rd_ptr < STORE_DEPTH &&
                store[active][rd_ptr].exponent == e)
            begin
                c = c + store[active][rd_ptr].coefficient;
                rd_ptr++;
            end
            if (c != '0)
            begin
                fresh_word.exponent    = e;
                fresh_word.coefficient = c;
                append_merged(fresh_word);
            end
        endfunction

        function void note_term(coef_t c, exp_t e, bit present, bit fresh, bit last);
            sum_term_t   item;
            int unsigned n;
            bit          flag;
            if (fresh)
            begin
                stored_n = 0;
                merged_n = 0;
                rd_ptr   = 0;
                lost     = 1'b0;
            end
            if (present)
                merge_term(c, e);
            if (!last)
                return;
            copy_lower('0, 1'b1);
            active   = active ^ 1'b1;
            stored_n = merged_n;
            merged_n = 0;
            rd_ptr   = 0;
            if (stored_n == 0)
            begin
                item.coefficient = '0;
                item.exponent    = '0;
                item.last_of_sum = 1'b1;
                item.overflowed  = lost;
                expected_terms.push_back(item);
                return;
            end
            n    = (stored_n > STORE_DEPTH) ? STORE_DEPTH : stored_n;
            flag = lost;
            if (n > MAX_RESULTS)
            begin
                n    = MAX_RESULTS;
                flag = 1'b1;
            end
            for (int unsigned k = 0; k < n; k++)
            begin
                item.coefficient = store[active][k].coefficient;
                item.exponent    = store[active][k].exponent;
                item.last_of_sum = (k + 1 == n);
                item.overflowed  = flag;
                expected_terms.push_back(item);
            end
        endfunction

        function void check_sum(sum_term_t got);
            sum_term_t want;
            if (expected_terms.size() == 0)
            begin
                $display("%0t: unexpected sum term coef %0d exp %0d last %0b ovf %0b",
                         $time, got.coefficient, got.exponent, got.last_of_sum,
                         got.overflowed);
                errors++;
                return;
            end
            want = expected_terms.pop_front();
            if (got.coefficient !== want.coefficient || got.exponent !== want.exponent ||
                got.last_of_sum !== want.last_of_sum || got.overflowed !== want.overflowed)
            begin
                $display({"%0t: sum term mismatch: expected coef %0d exp %0d last %0b ",
                          "ovf %0b, got coef %0d exp %0d last %0b ovf %0b"},
                         $time, want.coefficient, want.exponent, want.last_of_sum,
                         want.overflowed, got.coefficient, got.exponent, got.last_of_sum,
                         got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spa_term_if terms_ch ();
    spa_sum_if  sums_ch ();

    sparse_polynomial_add_unit #(
        .MAX_TERMS (STORE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .terms (terms_ch),
        .sums  (sums_ch)
    );

    poly_sum_scoreboard sb = new();

    int          send_idle_pct = 37;
    int          recv_stall_pct = 61;
    int unsigned terms_sent;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin : sum_monitor
        sum_term_t got;
        if (rst_n)
        begin
            if (sums_ch.valid && sums_ch.ready)
            begin
                got.coefficient = sums_ch.sum_coefficient;
                got.exponent    = sums_ch.sum_exponent;
                got.last_of_sum = sums_ch.last_of_sum;
                got.overflowed  = sums_ch.overflowed;
                sb.check_sum(got);
            end
            if (terms_ch.valid && terms_ch.ready)
                sb.note_term(terms_ch.coefficient, terms_ch.exponent, terms_ch.term_present,
                             terms_ch.start_new, terms_ch.last_term);
            if ((sums_ch.valid && sums_ch.ready) || (terms_ch.valid && terms_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        sums_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_term(coef_t c, exp_t e, bit present, bit fresh, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            terms_ch.valid <= 1'b0;
            @(posedge clk);
        end
        terms_ch.valid        <= 1'b1;
        terms_ch.coefficient  <= c;
        terms_ch.exponent     <= e;
        terms_ch.term_present <= present;
        terms_ch.start_new    <= fresh;
        terms_ch.last_term    <= last;
        do
            @(posedge clk);
        while (terms_ch.ready !== 1'b1);
        terms_sent++;
    endtask

    // Holds the term channel idle until every pending sum term has come out.
    task automatic hold_until_drained();
        terms_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic coef_t pick_coef();
        case ($urandom_range(9))
            0:       return coef_t'($urandom);
            1:       return ($urandom_range(1) == 1) ? coef_t'(32'h8000_0000) : coef_t'(-1);
            2:       return coef_t'(32'h7FFF_FFFF);
            default: return coef_t'(int'($urandom_range(16)) - 8);
        endcase
    endfunction

    // Sends one polynomial with strictly rising exponents drawn from a window.
    task automatic send_polynomial(bit fresh, int n_terms, int base, int unsigned spread);
        int  raw[$];
        int  exps[$];
        bit  blank_end;
        blank_end = ($urandom_range(9) == 0);
        for (int i = 0; i < n_terms; i++)
            raw.push_back(base + int'($urandom_range(spread)));
        raw.sort();
        foreach (raw[i])
            if (i == 0 || raw[i] != raw[i - 1])
                exps.push_back(raw[i]);
        if (exps.size() == 0)
        begin
            send_term(coef_t'($urandom), exp_t'($urandom), 1'b0, fresh, 1'b1);
            return;
        end
        foreach (exps[i])
            send_term(pick_coef(), exp_t'(exps[i]), 1'b1, fresh && i == 0,
                      !blank_end && i == exps.size() - 1);
        if (blank_end)
            send_term(coef_t'($urandom), exp_t'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    // A fresh sum followed by up to three further polynomials added into it over a shared window.
    task automatic send_series();
        int          polys;
        bit          long_run;
        int          base;
        int unsigned spread;
        int          n;
        polys    = $urandom_range(1, 4);
        long_run = ($urandom_range(9) == 0);
        spread   = long_run ? 80 : $urandom_range(4, 24);
        case ($urandom_range(4))
            0:       base = int'(32'h8000_0000) + int'($urandom_range(20));
            1:       base = int'(32'h7FFF_FFFF) - int'(spread) - int'($urandom_range(20));
            2:
            begin
                base   = int'($urandom);
                spread = 32'hFFFF_FFFF;
            end
            default: base = int'($urandom_range(60)) - 30;
        endcase
        for (int p = 0; p < polys; p++)
        begin
            n = long_run ? $urandom_range(16, 36) : $urandom_range(0, 8);
            send_polynomial(p == 0, n, base, spread);
        end
    endtask

    // Unstructured items: random flags, falling and repeated exponents, early restarts.
    task automatic send_noise();
        int   count;
        exp_t e;
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++)
        begin
            e = ($urandom_range(1) == 1) ? exp_t'($urandom)
                                         : exp_t'(int'($urandom_range(16)) - 8);
            send_term(pick_coef(), e, 1'($urandom_range(1)), $urandom_range(7) == 0,
                      $urandom_range(4) == 0);
        end
    endtask

    task automatic send_directed();
        // Empty polynomial gives the zero sum.
        send_term('0, '0, 1'b0, 1'b1, 1'b1);
        // Extremes of both fields.
        send_term(coef_t'(5), exp_t'(32'h8000_0000), 1'b1, 1'b1, 1'b0);
        send_term(coef_t'(-1), exp_t'(-1), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(32'h7FFF_FFFF), exp_t'(0), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(32'h8000_0000), exp_t'(32'h7FFF_FFFF), 1'b1, 1'b0, 1'b1);
        // Added into the sum: one term cancels, one wraps around.
        send_term(coef_t'(-5), exp_t'(32'h8000_0000), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(1), exp_t'(0), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(7), exp_t'(3), 1'b1, 1'b0, 1'b1);
        // Zero coefficient, falling exponent, repeated exponent adding to zero.
        send_term(coef_t'(0), exp_t'(10), 1'b1, 1'b1, 1'b0);
        send_term(coef_t'(4), exp_t'(12), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(3), exp_t'(20), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(9), exp_t'(15), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(2), exp_t'(20), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(-5), exp_t'(20), 1'b1, 1'b0, 1'b1);
        // An item with no term re-emits the sum unchanged.
        send_term(coef_t'(32'hDEAD_BEEF), exp_t'(32'h1234_5678), 1'b0, 1'b0, 1'b1);
        // Restart in the middle of a polynomial.
        send_term(coef_t'(1), exp_t'(1), 1'b1, 1'b1, 1'b0);
        send_term(coef_t'(2), exp_t'(2), 1'b1, 1'b0, 1'b0);
        send_term(coef_t'(3), exp_t'(3), 1'b1, 1'b1, 1'b0);
        send_term(coef_t'(4), exp_t'(4), 1'b1, 1'b0, 1'b1);
        // A sum that cancels completely.
        send_term(coef_t'(6), exp_t'(6), 1'b1, 1'b1, 1'b1);
        send_term(coef_t'(-6), exp_t'(6), 1'b1, 1'b0, 1'b1);
    endtask

    initial
    begin
        terms_ch.valid        <= 1'b0;
        terms_ch.coefficient  <= '0;
        terms_ch.exponent     <= '0;
        terms_ch.term_present <= 1'b0;
        terms_ch.start_new    <= 1'b0;
        terms_ch.last_term    <= 1'b0;
        rst_n                 <= 1'b0;
        terms_sent            = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        hold_until_drained();
        terms_sent = 0;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 61;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 37;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (terms_sent < (phase + 1) * RANDOM_TERMS / 3)
            begin
                if ($urandom_range(99) < 75)
                    send_series();
                else
                    send_noise();
                if ($urandom_range(99) < 4)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
